### design/pfpe_pkg.sv
// Shared constants, codes and payload types for the page frame buffer engine.
// No dependencies; every design file but pfpe_ram refers to it by scoped names.
package pfpe_pkg;

   // Screen geometry and store size
   localparam int COLUMNS     = 128;
   localparam int ROWS        = 64;
   localparam int PAGES       = (ROWS + 7) / 8;
   localparam int STORE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int PAGE_W      = 3;
   localparam int POS_W       = 8;
   localparam int COL_W       = $clog2(COLUMNS);
   localparam int HEADER_LEN  = 3;
   localparam int SCAN_LEN    = HEADER_LEN + COLUMNS;

   // Command opcodes
   localparam logic [1:0] OP_DRAW = 2'd0;
   localparam logic [1:0] OP_FILL = 2'd1;
   localparam logic [1:0] OP_SCAN = 2'd2;

   // Pen codes
   localparam logic [1:0] PEN_ERASE  = 2'd0;
   localparam logic [1:0] PEN_SET    = 2'd1;
   localparam logic [1:0] PEN_INVERT = 2'd2;

   // Scan-out header positions
   localparam logic [POS_W-1:0] POS_PAGE_CMD = POS_W'(0);
   localparam logic [POS_W-1:0] POS_COL_HIGH = POS_W'(1);
   localparam logic [POS_W-1:0] POS_COL_LOW  = POS_W'(2);

   // Panel command bytes
   localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
   localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
   localparam logic [7:0] CMD_COL_LOW   = 8'h00;
   localparam logic [7:0] FULL_BYTE     = 8'hFF;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [1:0]        pen;
      logic signed [7:0] x_coord;
      logic signed [7:0] y_coord;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       frame_last;
   } rsp_payload_type;

   // Scan counter view handed to the top level
   typedef struct packed {
      logic [7:0]        hdr_byte;
      logic              is_data;
      logic              last;
      logic [ADDR_W-1:0] addr;
   } scan_info_type;

   // Fill sequencer memory requests and status
   typedef struct packed {
      logic              busy;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
   } fill_port_type;

endpackage

### design/pfpe_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pfpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port: old data on a same-address write, hold when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/pfpe_scan.sv
// Scan-out position counter: page and byte position of the refresh stream.
// Depends on pfpe_pkg.
module pfpe_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   output pfpe_pkg::scan_info_type info
);

   logic [pfpe_pkg::PAGE_W-1:0] page_ff, page_in;
   logic [pfpe_pkg::PAGE_W:0]   page_inc;
   logic [pfpe_pkg::POS_W-1:0]  pos_ff, pos_in, pos_next, col_full;
   logic [pfpe_pkg::COL_W-1:0]  col;
   logic [7:0]                  hdr_byte;

   // Advance through header and data bytes, wrap page after the last column
   always_comb begin
      pos_next = pos_ff + 1'b1;
      page_inc = {1'b0, page_ff} + 1'b1;
      page_in  = page_ff;
      pos_in   = pos_ff;
      if (advance) begin
         if (pos_next >= pfpe_pkg::POS_W'(pfpe_pkg::SCAN_LEN)) begin
            pos_in = '0;
            if (page_inc >= (pfpe_pkg::PAGE_W + 1)'(pfpe_pkg::PAGES)) begin
               page_in = '0;
            end else begin
               page_in = page_inc[pfpe_pkg::PAGE_W-1:0];
            end
         end else begin
            pos_in = pos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff <= '0;
         pos_ff  <= '0;
      end else begin
         page_ff <= page_in;
         pos_ff  <= pos_in;
      end
   end

   // Header byte for the current position
   always_comb begin
      case (pos_ff)
         pfpe_pkg::POS_PAGE_CMD: hdr_byte = pfpe_pkg::CMD_PAGE_BASE + 8'(page_ff);
         pfpe_pkg::POS_COL_HIGH: hdr_byte = pfpe_pkg::CMD_COL_HIGH;
         pfpe_pkg::POS_COL_LOW:  hdr_byte = pfpe_pkg::CMD_COL_LOW;
         default:                hdr_byte = pfpe_pkg::CMD_COL_LOW;
      endcase
   end

   assign col_full = pos_ff - pfpe_pkg::POS_W'(pfpe_pkg::HEADER_LEN);
   assign col      = col_full[pfpe_pkg::COL_W-1:0];

   assign info.hdr_byte = hdr_byte;
   assign info.is_data  = (pos_ff >= pfpe_pkg::POS_W'(pfpe_pkg::HEADER_LEN));
   assign info.last     = info.is_data
                          && (col == pfpe_pkg::COL_W'(pfpe_pkg::COLUMNS - 1))
                          && (page_ff == pfpe_pkg::PAGE_W'(pfpe_pkg::PAGES - 1));
   assign info.addr     = pfpe_pkg::ADDR_W'(page_ff) * pfpe_pkg::ADDR_W'(pfpe_pkg::COLUMNS)
                          + pfpe_pkg::ADDR_W'(col);

endmodule

### design/pfpe_fill.sv
// Fill sequencer: sweeps the whole store one byte a cycle (set, clear, invert).
// Runs a clearing pass after reset. Depends on pfpe_pkg.
module pfpe_fill (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             pen,
   input  logic [7:0]             rd_data,
   output pfpe_pkg::fill_port_type port
);

   logic                        active_ff, active_in;
   logic [pfpe_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [1:0]                  pen_ff, pen_in;
   logic                        wr_vld_ff, wr_vld_in;
   logic [pfpe_pkg::ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [7:0]                  wr_data;

   // Read address walks the store; the write follows in the next cycle
   always_comb begin
      active_in  = active_ff;
      addr_in    = addr_ff;
      pen_in     = pen_ff;
      wr_vld_in  = active_ff;
      wr_addr_in = addr_ff;
      if (start) begin
         active_in = 1'b1;
         addr_in   = '0;
         pen_in    = pen;
      end else if (active_ff) begin
         addr_in = addr_ff + 1'b1;
         if (addr_ff == pfpe_pkg::ADDR_W'(pfpe_pkg::STORE_DEPTH - 1)) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         addr_ff   <= '0;
         pen_ff    <= pfpe_pkg::PEN_ERASE;
         wr_vld_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         addr_ff   <= addr_in;
         pen_ff    <= pen_in;
         wr_vld_ff <= wr_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
   end

   // New byte value by pen; clear, set, anything else inverts
   always_comb begin
      case (pen_ff)
         pfpe_pkg::PEN_SET:   wr_data = pfpe_pkg::FULL_BYTE;
         pfpe_pkg::PEN_ERASE: wr_data = '0;
         default:             wr_data = ~rd_data;
      endcase
   end

   assign port.busy    = active_ff || wr_vld_ff;
   assign port.rd_en   = active_ff;
   assign port.rd_addr = addr_ff;
   assign port.wr_en   = wr_vld_ff;
   assign port.wr_addr = wr_addr_ff;
   assign port.wr_data = wr_data;

endmodule

### design/page_framebuffer_pixel_engine_unit.sv
// Monochrome page frame buffer (128 x 8 pages) with pixel draw, fill and
// scan-out. Top level; depends on pfpe_pkg, pfpe_ram, pfpe_scan, pfpe_fill.
//
// Usage:
//  - req channel (req_valid/req_ready/req_payload) carries one command per
//    beat: draw pixel, fill buffer, or emit the next refresh byte.
//  - rsp channel (rsp_valid/rsp_ready/rsp_payload) carries one byte per
//    refresh command; draw and fill commands produce no rsp beat.
//  - Draw and refresh commands are taken one per cycle while req_ready is high.
//    Each reads the store in the accept cycle; a draw byte is modified and
//    written back in the next cycle, with a bypass for back-to-back hits on one byte.
//  - A refresh byte passes through the read stage and then the output
//    register before it appears on rsp; a rsp stall can hold it in either.
//  - A fill walks the 1024-byte store through the single read/write port
//    pair, one byte a cycle: req_ready stays low until the sweep is done.
//  - After reset the same sequencer clears the store: req_ready stays low
//    until it is done, and the scan-out restarts at page 0, first header byte.
//  - When rsp stalls, one refresh byte waits in the output register and a
//    second one in the read stage; req_ready drops only when the second is
//    blocked. Draw commands keep flowing while only the output is full.
module page_framebuffer_pixel_engine_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pfpe_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pfpe_pkg::rsp_payload_type rsp_payload
);

   pfpe_pkg::scan_info_type     scan_info;
   pfpe_pkg::fill_port_type     fill_port;

   logic                        accept;
   logic                        draw_ok;
   logic [7:0]                  x_u, y_u;
   logic [pfpe_pkg::ADDR_W-1:0] pix_addr;
   logic [7:0]                  pix_mask;

   logic                        ram_wr_en, ram_rd_en;
   logic [pfpe_pkg::ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]                  ram_wr_data, ram_rd_data;

   // Read stage registers
   logic                        s1_valid_ff, s1_valid_in;
   logic [1:0]                  s1_op_ff, s1_op_in;
   logic [1:0]                  s1_pen_ff, s1_pen_in;
   logic                        s1_draw_ff, s1_draw_in;
   logic [pfpe_pkg::ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   logic [7:0]                  s1_mask_ff, s1_mask_in;
   logic [7:0]                  s1_hdr_ff, s1_hdr_in;
   logic                        s1_is_data_ff, s1_is_data_in;
   logic                        s1_last_ff, s1_last_in;

   // Last write, kept for the bypass
   logic                        prev_wr_ff, prev_wr_in;
   logic [pfpe_pkg::ADDR_W-1:0] prev_addr_ff, prev_addr_in;
   logic [7:0]                  prev_data_ff, prev_data_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   pfpe_pkg::rsp_payload_type   rsp_payload_ff, rsp_payload_in;

   logic                        s1_is_scan, s1_stall, s1_scan_go, s1_wr;
   logic                        fill_start;
   logic [7:0]                  s1_rdata, s1_new;

   // Handshake and stage control
   assign s1_is_scan = s1_valid_ff && (s1_op_ff == pfpe_pkg::OP_SCAN);
   assign s1_stall   = s1_is_scan && rsp_valid_ff && !rsp_ready;
   assign s1_scan_go = s1_is_scan && !s1_stall;
   assign fill_start = s1_valid_ff && (s1_op_ff == pfpe_pkg::OP_FILL);
   assign req_ready  = !fill_port.busy && !fill_start && !s1_stall;
   assign accept     = req_valid && req_ready;

   // Decode pixel coordinates
   assign x_u      = req_payload.x_coord;
   assign y_u      = req_payload.y_coord;
   assign draw_ok  = !x_u[7] && (x_u < 8'(pfpe_pkg::COLUMNS))
                     && !y_u[7] && (y_u < 8'(pfpe_pkg::ROWS));
   assign pix_addr = pfpe_pkg::ADDR_W'(y_u[5:3]) * pfpe_pkg::ADDR_W'(pfpe_pkg::COLUMNS)
                     + pfpe_pkg::ADDR_W'(x_u[6:0]);
   assign pix_mask = 8'(1) << y_u[2:0];

   pfpe_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (accept && (req_payload.opcode == pfpe_pkg::OP_SCAN)),
      .info    (scan_info)
   );

   pfpe_fill u_fill (
      .clock   (clock),
      .reset   (reset),
      .start   (fill_start),
      .pen     (s1_pen_ff),
      .rd_data (ram_rd_data),
      .port    (fill_port)
   );

   // Read port: fill sweep or the accepted command
   always_comb begin
      if (fill_port.rd_en) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = fill_port.rd_addr;
      end else begin
         ram_rd_en   = accept && ((req_payload.opcode == pfpe_pkg::OP_DRAW)
                                  || (req_payload.opcode == pfpe_pkg::OP_SCAN));
         ram_rd_addr = (req_payload.opcode == pfpe_pkg::OP_SCAN) ? scan_info.addr
                                                                 : pix_addr;
      end
   end

   // Bypass the last write, then apply the pen
   assign s1_rdata = (prev_wr_ff && (prev_addr_ff == s1_addr_ff)) ? prev_data_ff
                                                                  : ram_rd_data;
   always_comb begin
      case (s1_pen_ff)
         pfpe_pkg::PEN_SET:    s1_new = s1_rdata | s1_mask_ff;
         pfpe_pkg::PEN_INVERT: s1_new = s1_rdata ^ s1_mask_ff;
         default:              s1_new = s1_rdata & ~s1_mask_ff;
      endcase
   end
   assign s1_wr = s1_valid_ff && (s1_op_ff == pfpe_pkg::OP_DRAW) && s1_draw_ff;

   // Write port: fill sweep or draw write-back
   always_comb begin
      if (fill_port.wr_en) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = fill_port.wr_addr;
         ram_wr_data = fill_port.wr_data;
      end else begin
         ram_wr_en   = s1_wr;
         ram_wr_addr = s1_addr_ff;
         ram_wr_data = s1_new;
      end
   end

   pfpe_ram #(
      .WIDTH (8),
      .DEPTH (pfpe_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Load the read stage on accept, hold it while stalled
   always_comb begin
      s1_valid_in   = accept || s1_stall;
      s1_op_in      = s1_op_ff;
      s1_pen_in     = s1_pen_ff;
      s1_draw_in    = s1_draw_ff;
      s1_addr_in    = s1_addr_ff;
      s1_mask_in    = s1_mask_ff;
      s1_hdr_in     = s1_hdr_ff;
      s1_is_data_in = s1_is_data_ff;
      s1_last_in    = s1_last_ff;
      if (accept) begin
         s1_op_in      = req_payload.opcode;
         s1_pen_in     = req_payload.pen;
         s1_draw_in    = draw_ok;
         s1_addr_in    = ram_rd_addr;
         s1_mask_in    = pix_mask;
         s1_hdr_in     = scan_info.hdr_byte;
         s1_is_data_in = scan_info.is_data;
         s1_last_in    = scan_info.last;
      end
   end

   // Track the last write; freeze while a read waits in the stage
   always_comb begin
      if (s1_stall) begin
         prev_wr_in   = prev_wr_ff;
         prev_addr_in = prev_addr_ff;
         prev_data_in = prev_data_ff;
      end else begin
         prev_wr_in   = ram_wr_en;
         prev_addr_in = ram_wr_addr;
         prev_data_in = ram_wr_data;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in   = s1_scan_go || (rsp_valid_ff && !rsp_ready);
      rsp_payload_in = rsp_payload_ff;
      if (s1_scan_go) begin
         rsp_payload_in.out_byte   = s1_is_data_ff ? s1_rdata : s1_hdr_ff;
         rsp_payload_in.is_data    = s1_is_data_ff;
         rsp_payload_in.frame_last = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         prev_wr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         prev_wr_ff   <= prev_wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff       <= s1_op_in;
      s1_pen_ff      <= s1_pen_in;
      s1_draw_ff     <= s1_draw_in;
      s1_addr_ff     <= s1_addr_in;
      s1_mask_ff     <= s1_mask_in;
      s1_hdr_ff      <= s1_hdr_in;
      s1_is_data_ff  <= s1_is_data_in;
      s1_last_ff     <= s1_last_in;
      prev_addr_ff   <= prev_addr_in;
      prev_data_ff   <= prev_data_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### design/pfpe_checker.sv
// Port-level checks for the page frame buffer engine, bound to the top level.
// Depends on pfpe_pkg and page_framebuffer_pixel_engine_unit.
module pfpe_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input pfpe_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input pfpe_pkg::rsp_payload_type rsp_payload
);

   // Clearing pass blocks commands right after reset
   a_reset_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req_ready high during the post-reset clearing pass");

   // A stalled rsp beat holds its byte
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat dropped or changed while stalled");

   // The frame flag only rides on a data byte
   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_last |-> rsp_payload.is_data)
      else $error("frame_last on a command byte");

   // Command bytes are page address or column address only
   a_cmd_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.is_data |->
         (rsp_payload.out_byte[7:3] == 5'b10110)
         || (rsp_payload.out_byte == pfpe_pkg::CMD_COL_HIGH)
         || (rsp_payload.out_byte == pfpe_pkg::CMD_COL_LOW))
      else $error("unexpected command byte on rsp");

endmodule

bind page_framebuffer_pixel_engine_unit pfpe_checker u_pfpe_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

### dv/tb_page_framebuffer_pixel_engine_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for page_framebuffer_pixel_engine_unit: draw, fill and refresh
// commands go in, refresh beats are checked against a frame buffer predictor.
// Depends on pfpe_pkg and the design files under design/.
module tb_page_framebuffer_pixel_engine_unit;

   localparam int CYCLE_LIMIT       = 600000;
   localparam int RSP_HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS      = 640;
   localparam int DRAIN_CYCLES      = 20;
   localparam int MAX_GAP           = 17;
   localparam int PRESSURE_AT_ITEM  = 300;
   localparam int PRESSURE_BURST    = 40;

   // Codes the package leaves unnamed
   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam logic [1:0] PEN_RESERVED = 2'd3;

   // Frame buffer predictor plus the queue of refresh beats still owed
   class frame_scoreboard;
      logic [7:0]                pixels [pfpe_pkg::STORE_DEPTH];
      int                        scan_page;
      int                        scan_position;
      pfpe_pkg::rsp_payload_type expected_q[$];
      int                        errors;

      function new();
         foreach (pixels[i]) pixels[i] = 8'h00;
         scan_page     = 0;
         scan_position = 0;
         errors        = 0;
      endfunction

      // Apply one accepted command to the predicted buffer and scan state
      function void note_command(pfpe_pkg::req_payload_type cmd);
         int                        col;
         int                        row;
         int                        addr;
         logic [7:0]                bit_mask;
         pfpe_pkg::rsp_payload_type beat;
         case (cmd.opcode)
            pfpe_pkg::OP_DRAW: begin
               col = $signed(cmd.x_coord);
               row = $signed(cmd.y_coord);
               // drop pixels that fall off the screen
               if (col >= 0 && col < pfpe_pkg::COLUMNS && row >= 0 && row < pfpe_pkg::ROWS)
               begin
                  addr = ((row / 8) * pfpe_pkg::COLUMNS + col) % pfpe_pkg::STORE_DEPTH;
                  bit_mask = 8'h01 << (row % 8);
                  if (cmd.pen == pfpe_pkg::PEN_SET)
                     pixels[addr] = pixels[addr] | bit_mask;
                  else if (cmd.pen == pfpe_pkg::PEN_INVERT)
                     pixels[addr] = pixels[addr] ^ bit_mask;
                  else
                     pixels[addr] = pixels[addr] & ~bit_mask;
               end
            end
            pfpe_pkg::OP_FILL: begin
               // reserved pen inverts, like the invert pen
               foreach (pixels[i]) begin
                  if (cmd.pen == pfpe_pkg::PEN_SET)
                     pixels[i] = pfpe_pkg::FULL_BYTE;
                  else if (cmd.pen == pfpe_pkg::PEN_ERASE)
                     pixels[i] = 8'h00;
                  else
                     pixels[i] = ~pixels[i];
               end
            end
            pfpe_pkg::OP_SCAN: begin
               beat = '0;
               if (scan_position == pfpe_pkg::POS_PAGE_CMD)
                  beat.out_byte = pfpe_pkg::CMD_PAGE_BASE + 8'(scan_page);
               else if (scan_position == pfpe_pkg::POS_COL_HIGH)
                  beat.out_byte = pfpe_pkg::CMD_COL_HIGH;
               else if (scan_position == pfpe_pkg::POS_COL_LOW)
                  beat.out_byte = pfpe_pkg::CMD_COL_LOW;
               else begin
                  col = scan_position - pfpe_pkg::HEADER_LEN;
                  beat.out_byte = pixels[(scan_page * pfpe_pkg::COLUMNS + col)
                                         % pfpe_pkg::STORE_DEPTH];
                  beat.is_data = 1'b1;
                  beat.frame_last = (col == pfpe_pkg::COLUMNS - 1)
                                    && (scan_page == pfpe_pkg::PAGES - 1);
               end
               expected_q.push_back(beat);
               // advance the scan, wrap to the next page and then to page 0
               scan_position++;
               if (scan_position >= pfpe_pkg::SCAN_LEN) begin
                  scan_position = 0;
                  scan_page = (scan_page + 1) % 8;
                  if (scan_page >= pfpe_pkg::PAGES) scan_page = 0;
               end
            end
            default: ;
         endcase
      endfunction

      // Compare one refresh beat with the oldest one owed
      function void check_beat(pfpe_pkg::rsp_payload_type got);
         pfpe_pkg::rsp_payload_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: refresh beat with none owed: expected nothing, actual %h",
                     $time, got);
            return;
         end
         want = expected_q.pop_front();
         if (got.out_byte !== want.out_byte) begin
            errors++;
            $display("%0t: out_byte mismatch: expected %h, actual %h",
                     $time, want.out_byte, got.out_byte);
         end
         if (got.is_data !== want.is_data) begin
            errors++;
            $display("%0t: is_data mismatch: expected %b, actual %b",
                     $time, want.is_data, got.is_data);
         end
         if (got.frame_last !== want.frame_last) begin
            errors++;
            $display("%0t: frame_last mismatch: expected %b, actual %b",
                     $time, want.frame_last, got.frame_last);
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   pfpe_pkg::req_payload_type req_payload;
   logic                      rsp_valid;
   logic                      rsp_ready;
   pfpe_pkg::rsp_payload_type rsp_payload;

   frame_scoreboard board;
   bit              sender_quiet;
   bit              hold_rsp;
   int              cycle_count;

   page_framebuffer_pixel_engine_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Bound the run
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("page_framebuffer_pixel_engine_unit verification failed");
         $finish;
      end
   end

   // Check every refresh beat taken by the receiver
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_beat(rsp_payload);
   end

   function automatic pfpe_pkg::req_payload_type make_cmd(logic [1:0] opcode,
                                                          logic [1:0] pen,
                                                          int col, int row);
      pfpe_pkg::req_payload_type cmd;
      cmd.opcode  = opcode;
      cmd.pen     = pen;
      cmd.x_coord = 8'(col);
      cmd.y_coord = 8'(row);
      return cmd;
   endfunction

   // Sender gap; flip now and then into a stretch with no gaps
   function automatic int next_gap();
      if ($urandom_range(0, 39) == 0) sender_quiet = !sender_quiet;
      return sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic pfpe_pkg::req_payload_type random_command();
      int                        pick;
      pfpe_pkg::req_payload_type cmd;
      pick = $urandom_range(0, 99);
      cmd.pen     = 2'($urandom_range(0, 3));
      cmd.x_coord = 8'($urandom_range(0, 255));
      cmd.y_coord = 8'($urandom_range(0, 255));
      if (pick < 60)
         cmd.opcode = pfpe_pkg::OP_SCAN;
      else if (pick < 93) begin
         cmd.opcode = pfpe_pkg::OP_DRAW;
         // keep most pixels on screen so refresh beats show them
         if ($urandom_range(0, 9) != 0) begin
            cmd.x_coord = 8'($urandom_range(0, pfpe_pkg::COLUMNS - 1));
            cmd.y_coord = 8'($urandom_range(0, pfpe_pkg::ROWS - 1));
         end
      end
      else if (pick < 95)
         cmd.opcode = pfpe_pkg::OP_FILL;
      else
         cmd.opcode = OP_UNUSED;
      return cmd;
   endfunction

   // Offer one command after a gap and hold it until the beat is taken
   task automatic send_command(input pfpe_pkg::req_payload_type cmd, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= cmd;
      do @(posedge clock); while (!req_ready);
      board.note_command(cmd);
   endtask

   // Receiver: random stalls, quiet stretches and one long hold
   initial begin : rsp_side
      int stall;
      bit rsp_quiet;
      rsp_quiet = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_quiet = !rsp_quiet;
         if (hold_rsp) begin
            stall = RSP_HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         else
            stall = rsp_quiet ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : req_side
      pfpe_pkg::req_payload_type cmd;
      int                        item_index;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      sender_quiet = 1'b0;
      hold_rsp     = 1'b0;
      item_index   = 0;
      board        = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Corners, off-screen pixels, reserved codes
      send_command(make_cmd(pfpe_pkg::OP_DRAW, pfpe_pkg::PEN_SET, 0, 0), next_gap());
      send_command(make_cmd(pfpe_pkg::OP_DRAW, pfpe_pkg::PEN_SET,
                            pfpe_pkg::COLUMNS - 1, pfpe_pkg::ROWS - 1), next_gap());
      send_command(make_cmd(pfpe_pkg::OP_DRAW, pfpe_pkg::PEN_INVERT,
                            pfpe_pkg::COLUMNS - 1, 0), next_gap());
      send_command(make_cmd(pfpe_pkg::OP_DRAW, pfpe_pkg::PEN_SET, 1, 7), next_gap());
      send_command(make_cmd(pfpe_pkg::OP_DRAW, pfpe_pkg::PEN_SET, -1, 5), next_gap());
      send_command(make_cmd(pfpe_pkg::OP_DRAW, pfpe_pkg::PEN_SET, 5, pfpe_pkg::ROWS),
                   next_gap());
      send_command(make_cmd(pfpe_pkg::OP_DRAW, pfpe_pkg::PEN_SET, -128, -128), next_gap());
      send_command(make_cmd(pfpe_pkg::OP_DRAW, pfpe_pkg::PEN_SET, 127, 127), next_gap());
      send_command(make_cmd(pfpe_pkg::OP_DRAW, PEN_RESERVED, 0, 0), next_gap());
      send_command(make_cmd(pfpe_pkg::OP_DRAW, pfpe_pkg::PEN_SET, 0, 1), next_gap());
      send_command(make_cmd(OP_UNUSED, pfpe_pkg::PEN_SET, 0, 0), next_gap());
      // Header bytes and the first data bytes of page 0
      repeat (5) send_command(make_cmd(pfpe_pkg::OP_SCAN, pfpe_pkg::PEN_ERASE, 0, 0),
                              next_gap());
      // Every fill pen; all but the erase fill are followed by a look at the buffer
      send_command(make_cmd(pfpe_pkg::OP_FILL, pfpe_pkg::PEN_SET, 0, 0), next_gap());
      repeat (2) send_command(make_cmd(pfpe_pkg::OP_SCAN, pfpe_pkg::PEN_ERASE, 0, 0),
                              next_gap());
      send_command(make_cmd(pfpe_pkg::OP_FILL, PEN_RESERVED, 0, 0), next_gap());
      send_command(make_cmd(pfpe_pkg::OP_SCAN, pfpe_pkg::PEN_ERASE, 0, 0), next_gap());
      send_command(make_cmd(pfpe_pkg::OP_FILL, pfpe_pkg::PEN_INVERT, 0, 0), next_gap());
      send_command(make_cmd(pfpe_pkg::OP_SCAN, pfpe_pkg::PEN_ERASE, 0, 0), next_gap());
      send_command(make_cmd(pfpe_pkg::OP_FILL, pfpe_pkg::PEN_ERASE, 0, 0), next_gap());
      send_command(make_cmd(pfpe_pkg::OP_DRAW, pfpe_pkg::PEN_ERASE,
                            pfpe_pkg::COLUMNS - 1, pfpe_pkg::ROWS - 1), next_gap());

      // Random mix
      while (item_index < RANDOM_ITEMS) begin
         if (item_index == PRESSURE_AT_ITEM) begin
            // hold the receiver and keep refresh beats coming so the input stalls
            hold_rsp = 1'b1;
            repeat (PRESSURE_BURST)
               send_command(make_cmd(pfpe_pkg::OP_SCAN, pfpe_pkg::PEN_ERASE, 0, 0), 0);
         end
         cmd = random_command();
         send_command(cmd, next_gap());
         item_index++;
      end
      req_valid <= 1'b0;

      // Drain owed beats, then let the pipeline settle
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("page_framebuffer_pixel_engine_unit verification clean");
      else
         $display("page_framebuffer_pixel_engine_unit verification failed");
      $finish;
   end

endmodule
